/* src/tlod_pkg.sv */
// tlod_pkg: shared constants, types and helper functions for the toroidal
// tile LOD scheduler. No dependencies.
`default_nettype none

package tlod_pkg;

    localparam int GRID_LOG2 = 3;                 // grid side is a power of two
    localparam int GRID_SIDE = 1 << GRID_LOG2;
    localparam int SLOT_W    = 2 * GRID_LOG2;
    localparam int SLOTS     = 1 << SLOT_W;
    localparam int RING_STEP = 2;                 // rings per detail level
    localparam int CAM_W     = 24;
    localparam int FRAC_W    = 8;
    localparam int TILE_W    = 17;
    localparam int LVL_W     = 3;
    localparam int LOD_W     = 4;
    localparam int MAX_LODS  = 1 << LVL_W;
    localparam int DIST_W    = GRID_LOG2 - 1;     // per-axis distance width
    localparam int ENTRY_W   = 2 * TILE_W + LVL_W;

    localparam logic [LOD_W-1:0] LOD_RESET = LOD_W'(4);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PRIME,
        ST_RUN
    } t_state;

    // Slot lookup and candidate position handed to the level evaluator
    typedef struct packed {
        logic                     hit_valid;
        logic signed [TILE_W-1:0] held_x;
        logic signed [TILE_W-1:0] held_y;
        logic [LVL_W-1:0]         held_level;
        logic signed [TILE_W-1:0] tile_x;
        logic signed [TILE_W-1:0] tile_y;
        logic [GRID_LOG2-1:0]     col;
        logic [GRID_LOG2-1:0]     row;
        logic [LOD_W-1:0]         lod_levels;
    } t_eval_req;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             reinit;
    } t_eval_rsp;

    // Round 8-fraction-bit fixed point half away from zero
    function automatic logic signed [TILE_W-1:0] round_centre(
        input logic signed [CAM_W-1:0] v);
        logic [CAM_W:0]    mag;
        logic [CAM_W:0]    sum;
        logic [TILE_W-1:0] q;
        mag = v[CAM_W-1] ? ((CAM_W+1)'(0) - {v[CAM_W-1], v}) : {1'b0, v};
        sum = mag + (CAM_W+1)'(1 << (FRAC_W - 1));
        q   = sum[FRAC_W +: TILE_W];
        return v[CAM_W-1] ? $signed(TILE_W'(0) - q) : $signed(q);
    endfunction

    // Absolute tile coordinate: centre plus (index - GRID_SIDE/2)
    function automatic logic signed [TILE_W-1:0] tile_of(
        input logic signed [TILE_W-1:0] c,
        input logic [GRID_LOG2-1:0]     idx);
        logic [TILE_W-1:0] d;
        d = {{(TILE_W-GRID_LOG2+1){~idx[GRID_LOG2-1]}}, idx[GRID_LOG2-2:0]};
        return $signed(c + d);
    endfunction

    // Toroidal slot of grid position pos around centre (cx, cz)
    function automatic logic [SLOT_W-1:0] slot_of(
        input logic [GRID_LOG2-1:0] cx_lo,
        input logic [GRID_LOG2-1:0] cz_lo,
        input logic [SLOT_W-1:0]    pos);
        logic [GRID_LOG2-1:0] xm;
        logic [GRID_LOG2-1:0] ym;
        xm = cx_lo + pos[GRID_LOG2-1:0] + GRID_LOG2'(GRID_SIDE / 2);
        ym = cz_lo + pos[SLOT_W-1:GRID_LOG2] + GRID_LOG2'(GRID_SIDE / 2);
        return {ym, xm};
    endfunction

endpackage

`default_nettype wire

/* src/tlod_ifs.sv */
// tlod_cam_if / tlod_res_if: valid-ready channels for camera words and slot
// result words. Depends on tlod_pkg.
`default_nettype none

interface tlod_cam_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [tlod_pkg::CAM_W-1:0]       camera_x;
    logic signed [tlod_pkg::CAM_W-1:0]       camera_z;

    modport source (output valid, output camera_x, output camera_z, input ready);
    modport sink   (input valid, input camera_x, input camera_z, output ready);
endinterface

interface tlod_res_if;
    logic                                    valid;
    logic                                    ready;
    logic [tlod_pkg::SLOT_W-1:0]             slot;
    logic signed [tlod_pkg::TILE_W-1:0]      tile_x;
    logic signed [tlod_pkg::TILE_W-1:0]      tile_y;
    logic [tlod_pkg::LVL_W-1:0]              level;
    logic                                    reinit;
    logic                                    last;

    modport source (output valid, output slot, output tile_x, output tile_y,
                    output level, output reinit, output last, input ready);
    modport sink   (input valid, input slot, input tile_x, input tile_y,
                    input level, input reinit, input last, output ready);
endinterface

`default_nettype wire

/* src/tlod_eval.sv */
// tlod_eval: per-slot level decision (reinit check, distance level, step-down).
// Depends on tlod_pkg.
`default_nettype none

module tlod_eval (
    input  wire tlod_pkg::t_eval_req i_req,
    output tlod_pkg::t_eval_rsp      o_rsp
);

    logic [tlod_pkg::LVL_W-1:0]  coarse;
    logic [tlod_pkg::DIST_W-1:0] ax;
    logic [tlod_pkg::DIST_W-1:0] ay;
    logic [tlod_pkg::DIST_W-1:0] amax;
    logic [tlod_pkg::LVL_W-1:0]  ring_lvl;
    logic [tlod_pkg::LVL_W-1:0]  down;
    logic [tlod_pkg::LVL_W-1:0]  keep_lvl;
    logic                        stale;

    always_comb begin
        // clamp lod_levels to 1..8, coarsest = levels - 1
        if (i_req.lod_levels == '0) begin
            coarse = '0;
        end else if (i_req.lod_levels > tlod_pkg::LOD_W'(tlod_pkg::MAX_LODS)) begin
            coarse = tlod_pkg::LVL_W'(tlod_pkg::MAX_LODS - 1);
        end else begin
            coarse = tlod_pkg::LVL_W'(i_req.lod_levels - tlod_pkg::LOD_W'(1));
        end

        // negative offset d counts as -d-1: top index bit clear means d < 0
        ax = i_req.col[tlod_pkg::GRID_LOG2-1] ? i_req.col[tlod_pkg::DIST_W-1:0]
                                              : ~i_req.col[tlod_pkg::DIST_W-1:0];
        ay = i_req.row[tlod_pkg::GRID_LOG2-1] ? i_req.row[tlod_pkg::DIST_W-1:0]
                                              : ~i_req.row[tlod_pkg::DIST_W-1:0];
        amax = (ax > ay) ? ax : ay;
        ring_lvl = tlod_pkg::LVL_W'(amax / tlod_pkg::RING_STEP);
        if (ring_lvl > coarse) begin
            ring_lvl = coarse;
        end

        down = (i_req.held_level != '0) ? i_req.held_level - tlod_pkg::LVL_W'(1) : '0;
        keep_lvl = (down > ring_lvl) ? down : ring_lvl;

        stale = !i_req.hit_valid || (i_req.held_x != i_req.tile_x)
                || (i_req.held_y != i_req.tile_y);

        if (stale) begin
            o_rsp.level  = coarse;
            o_rsp.reinit = 1'b1;
        end else begin
            o_rsp.level  = keep_lvl;
            o_rsp.reinit = (keep_lvl != i_req.held_level);
        end
    end

endmodule

`default_nettype wire

/* src/toroidal_tile_lod_scheduler.sv */
// toroidal_tile_lod_scheduler: top level; slot table memory, sweep sequencer,
// output register. Depends on tlod_pkg, tlod_ifs, tlod_eval.
`default_nettype none

// Each camera word is rounded to a grid centre and then the 8x8 window of
// tile positions around it is swept in row-major order, one position per
// cycle while the result side does not stall. Every position maps to a slot
// of a 64-entry toroidal table (low three bits of each tile coordinate); the
// table entry is read, the level decision is made, and the entry is written
// back when the slot is rebuilt or its level changes. One result word goes
// out per slot, 64 per camera word, with last set on the final one.
// Sequence of one update: accept, round the centre, prime the table read,
// then read-modify-write of every position through the single-port-read
// table, whose read is registered. A stall on the result side freezes the sweep.
// A new camera word is accepted only once the previous sweep has written its
// last slot, so the sweeps never overlap on the table. The valid bits live in
// flip-flops and are cleared by reset; no clearing pass is needed.
// lod_levels is to be written through i_cfg_we/i_cfg_wdata only while idle;
// the block does not enforce this. 0 acts as 1 and values above 8 act as 8.

module toroidal_tile_lod_scheduler (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [tlod_pkg::LOD_W-1:0]   i_cfg_wdata,
    tlod_cam_if.sink                    i_cam,
    tlod_res_if.source                  o_res
);

    // ---------------------------------------------------------------
    // Control and data registers
    // ---------------------------------------------------------------
    tlod_pkg::t_state                   r_state, n_state;
    logic [tlod_pkg::LOD_W-1:0]         r_lod;
    logic signed [tlod_pkg::CAM_W-1:0]  r_cam_x, r_cam_z;
    logic signed [tlod_pkg::TILE_W-1:0] r_cx, r_cz;
    logic [tlod_pkg::SLOT_W-1:0]        r_pos;
    logic [tlod_pkg::SLOTS-1:0]         r_valid;

    // Slot table: {tile_x, tile_y, level}
    logic [tlod_pkg::ENTRY_W-1:0]       r_mem [tlod_pkg::SLOTS];
    logic [tlod_pkg::ENTRY_W-1:0]       r_rd_q;

    // Output register
    logic                               r_out_valid;
    logic [tlod_pkg::SLOT_W-1:0]        r_out_slot;
    logic signed [tlod_pkg::TILE_W-1:0] r_out_tx, r_out_ty;
    logic [tlod_pkg::LVL_W-1:0]         r_out_level;
    logic                               r_out_reinit;
    logic                               r_out_last;

    // ---------------------------------------------------------------
    // Sweep datapath
    // ---------------------------------------------------------------
    logic                               accept;
    logic                               run;
    logic                               fire;
    logic                               last_pos;
    logic [tlod_pkg::SLOT_W-1:0]        cur_slot;
    logic [tlod_pkg::SLOT_W-1:0]        nxt_slot;
    logic [tlod_pkg::SLOT_W-1:0]        rd_addr;
    logic signed [tlod_pkg::TILE_W-1:0] cur_tx, cur_ty;
    tlod_pkg::t_eval_req                eval_req;
    tlod_pkg::t_eval_rsp                eval_rsp;

    assign accept   = i_cam.valid && i_cam.ready;
    assign last_pos = (r_pos == tlod_pkg::SLOT_W'(tlod_pkg::SLOTS - 1));
    // a position retires when the output register is free or draining
    assign fire     = run && (!r_out_valid || o_res.ready);

    assign cur_slot = tlod_pkg::slot_of(r_cx[tlod_pkg::GRID_LOG2-1:0],
                                        r_cz[tlod_pkg::GRID_LOG2-1:0], r_pos);
    assign nxt_slot = tlod_pkg::slot_of(r_cx[tlod_pkg::GRID_LOG2-1:0],
                                        r_cz[tlod_pkg::GRID_LOG2-1:0],
                                        r_pos + tlod_pkg::SLOT_W'(1));
    assign cur_tx   = tlod_pkg::tile_of(r_cx, r_pos[tlod_pkg::GRID_LOG2-1:0]);
    assign cur_ty   = tlod_pkg::tile_of(r_cz,
                                        r_pos[tlod_pkg::SLOT_W-1:tlod_pkg::GRID_LOG2]);

    // Read address runs one position ahead of the evaluation when it retires,
    // and re-reads the current slot while stalled.
    always_comb begin
        if (fire) begin
            rd_addr = nxt_slot;
        end else begin
            rd_addr = cur_slot;
        end
    end

    always_comb begin
        eval_req.hit_valid  = r_valid[cur_slot];
        eval_req.held_x     = $signed(r_rd_q[tlod_pkg::ENTRY_W-1 -: tlod_pkg::TILE_W]);
        eval_req.held_y     = $signed(r_rd_q[tlod_pkg::LVL_W +: tlod_pkg::TILE_W]);
        eval_req.held_level = r_rd_q[tlod_pkg::LVL_W-1:0];
        eval_req.tile_x     = cur_tx;
        eval_req.tile_y     = cur_ty;
        eval_req.col        = r_pos[tlod_pkg::GRID_LOG2-1:0];
        eval_req.row        = r_pos[tlod_pkg::SLOT_W-1:tlod_pkg::GRID_LOG2];
        eval_req.lod_levels = r_lod;
    end

    tlod_eval u_eval (
        .i_req (eval_req),
        .o_rsp (eval_rsp)
    );

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlod_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = tlod_pkg::ST_ROUND;
                end
            end
            tlod_pkg::ST_ROUND: begin
                n_state = tlod_pkg::ST_PRIME;
            end
            tlod_pkg::ST_PRIME: begin
                n_state = tlod_pkg::ST_RUN;
            end
            tlod_pkg::ST_RUN: begin
                if (fire && last_pos) begin
                    n_state = tlod_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tlod_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        i_cam.ready = 1'b0;
        run         = 1'b0;
        case (r_state)
            tlod_pkg::ST_IDLE:  i_cam.ready = 1'b1;
            tlod_pkg::ST_ROUND: ;
            tlod_pkg::ST_PRIME: ;
            tlod_pkg::ST_RUN:   run = 1'b1;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlod_pkg::ST_IDLE;
            r_lod       <= tlod_pkg::LOD_RESET;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_lod <= i_cfg_wdata;
            end
            if (r_state == tlod_pkg::ST_PRIME) begin
                r_pos <= '0;
            end else if (fire) begin
                r_pos <= r_pos + tlod_pkg::SLOT_W'(1);
            end
            if (fire && eval_rsp.reinit) begin
                r_valid[cur_slot] <= 1'b1;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cam_x <= i_cam.camera_x;
            r_cam_z <= i_cam.camera_z;
        end
        if (r_state == tlod_pkg::ST_ROUND) begin
            r_cx <= tlod_pkg::round_centre(r_cam_x);
            r_cz <= tlod_pkg::round_centre(r_cam_z);
        end
        if (fire) begin
            r_out_slot   <= cur_slot;
            r_out_tx     <= cur_tx;
            r_out_ty     <= cur_ty;
            r_out_level  <= eval_rsp.level;
            r_out_reinit <= eval_rsp.reinit;
            r_out_last   <= last_pos;
        end
    end

    // Slot table: one write, one registered read per cycle. Within a sweep
    // every slot is touched once, so read and write never meet on one entry.
    always_ff @(posedge i_clk) begin
        if (fire && eval_rsp.reinit) begin
            r_mem[cur_slot] <= {cur_tx, cur_ty, eval_rsp.level};
        end
        r_rd_q <= r_mem[rd_addr];
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.slot   = r_out_slot;
    assign o_res.tile_x = r_out_tx;
    assign o_res.tile_y = r_out_ty;
    assign o_res.level  = r_out_level;
    assign o_res.reinit = r_out_reinit;
    assign o_res.last   = r_out_last;

endmodule

`default_nettype wire

/* tb/toroidal_tile_lod_scheduler_tb.sv */
// Self-checking bench for toroidal_tile_lod_scheduler: a class tracks the slot
// table and LOD register and predicts every slot word of each sweep.
// Depends on tlod_pkg, tlod_ifs and the scheduler RTL.

module toroidal_tile_lod_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE          = tlod_pkg::GRID_SIDE;
    localparam int NSLOT         = tlod_pkg::SLOTS;
    localparam int STEP          = tlod_pkg::RING_STEP;
    localparam int HALF_LSB      = 1 << (tlod_pkg::FRAC_W - 1);
    localparam int CAM_MIN       = -(1 << (tlod_pkg::CAM_W - 1));
    localparam int CAM_MAX       = (1 << (tlod_pkg::CAM_W - 1)) - 1;
    localparam int IDLE_LIMIT    = 2000;   // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 4;      // after last word, before a cfg write
    localparam int DRAIN_CYCLES  = 70;     // idle wait at the very end, after the last word
    localparam int PHASE_ITEMS   = 45;
    localparam int PRESSURE_AT   = 3000;   // words seen before the long hold-off
    localparam int PRESSURE_LEN  = 400;
    localparam int MAX_REPORTS   = 40;

    // lod_levels per random phase: out-of-range and boundary values included
    localparam logic [tlod_pkg::LOD_W-1:0] PHASE_LODS [10] =
        '{4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd6, 4'd2, 4'd5, 4'd7, 4'd4};

    // One result word as it leaves the block
    typedef struct packed {
        logic [tlod_pkg::SLOT_W-1:0]        slot;
        logic signed [tlod_pkg::TILE_W-1:0] tile_x;
        logic signed [tlod_pkg::TILE_W-1:0] tile_y;
        logic [tlod_pkg::LVL_W-1:0]         level;
        logic                               reinit;
        logic                               last;
    } t_slot_word;

    // Shadow of the slot table plus the queue of words each sweep should emit.
    class lod_sweep_tracker;
        int                         held_x[NSLOT];
        int                         held_y[NSLOT];
        int                         held_level[NSLOT];
        bit                         held_valid[NSLOT];
        logic [tlod_pkg::LOD_W-1:0] lod_levels;
        t_slot_word                 due_words[$];
        int                         mismatch_count;

        function new();
            lod_levels     = tlod_pkg::LOD_RESET;
            mismatch_count = 0;
            foreach (held_valid[i]) begin
                held_x[i]     = 0;
                held_y[i]     = 0;
                held_level[i] = 0;
                held_valid[i] = 1'b0;
            end
        endfunction

        function void set_lod(logic [tlod_pkg::LOD_W-1:0] v);
            lod_levels = v;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        // 8 fraction bits, half away from zero
        function int centre_of(int v);
            if (v < 0)
                return -((-v + HALF_LSB) >> tlod_pkg::FRAC_W);
            return (v + HALF_LSB) >> tlod_pkg::FRAC_W;
        endfunction

        // negative offsets count one less, so the window is symmetric
        function int axis_dist(int d);
            return (d < 0) ? -d - 1 : d;
        endfunction

        function void take_camera(logic signed [tlod_pkg::CAM_W-1:0] cam_x,
                                  logic signed [tlod_pkg::CAM_W-1:0] cam_z);
            int         cx;
            int         cz;
            int         top;
            int         dx;
            int         dy;
            int         tx;
            int         ty;
            int         s;
            int         lvl;
            int         ring;
            int         down;
            bit         rebuild;
            t_slot_word w;
            cx = centre_of(int'(cam_x));
            cz = centre_of(int'(cam_z));
            if (lod_levels == 0)
                top = 0;
            else if (lod_levels > tlod_pkg::MAX_LODS)
                top = tlod_pkg::MAX_LODS - 1;
            else
                top = int'(lod_levels) - 1;
            for (int i = 0; i < NSLOT; i++) begin
                dx = i % SIDE - SIDE / 2;
                dy = i / SIDE - SIDE / 2;
                tx = cx + dx;
                ty = cz + dy;
                s  = ((tx % SIDE + SIDE) % SIDE) + SIDE * ((ty % SIDE + SIDE) % SIDE);
                rebuild = !held_valid[s] || held_x[s] != tx || held_y[s] != ty;
                if (rebuild) begin
                    lvl = top;
                end else begin
                    ring = axis_dist(dx) > axis_dist(dy) ? axis_dist(dx) : axis_dist(dy);
                    ring = ring / STEP;
                    if (ring > top)
                        ring = top;
                    down = held_level[s] > 0 ? held_level[s] - 1 : 0;
                    lvl  = down > ring ? down : ring;
                    rebuild = lvl != held_level[s];
                end
                if (rebuild) begin
                    held_x[s]     = tx;
                    held_y[s]     = ty;
                    held_level[s] = lvl;
                    held_valid[s] = 1'b1;
                end
                w.slot   = tlod_pkg::SLOT_W'(s);
                w.tile_x = tlod_pkg::TILE_W'(tx);
                w.tile_y = tlod_pkg::TILE_W'(ty);
                w.level  = tlod_pkg::LVL_W'(held_level[s]);
                w.reinit = rebuild;
                w.last   = (i == NSLOT - 1);
                due_words.insert(due_words.size(), w);
            end
        endfunction

        function void check_word(t_slot_word got);
            t_slot_word want;
            if (due_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected word: expected none, got slot=%0d x=%0d y=%0d",
                             $time, got.slot, got.tile_x, got.tile_y);
                return;
            end
            want = due_words.pop_front();
            if (got.slot !== want.slot || got.tile_x !== want.tile_x ||
                got.tile_y !== want.tile_y || got.level !== want.level ||
                got.reinit !== want.reinit || got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display({"%0t: word mismatch: expected slot=%0d x=%0d y=%0d lvl=%0d ",
                              "re=%0b last=%0b, got slot=%0d x=%0d y=%0d lvl=%0d re=%0b ",
                              "last=%0b"},
                             $time, want.slot, want.tile_x, want.tile_y, want.level,
                             want.reinit, want.last, got.slot, got.tile_x, got.tile_y,
                             got.level, got.reinit, got.last);
            end
        endfunction
    endclass

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [tlod_pkg::LOD_W-1:0] i_cfg_wdata = '0;

    tlod_cam_if cam_ch ();
    tlod_res_if res_ch ();

    toroidal_tile_lod_scheduler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cam       (cam_ch),
        .o_res       (res_ch)
    );

    lod_sweep_tracker tracker;

    int words_seen    = 0;
    int stall_left    = 0;   // further cycles the result side holds ready low
    int calm_left     = 0;   // further cycles of ready held high, no stalls
    bit pressure_done = 1'b0;
    int roll          = 0;
    bit sender_calm   = 1'b0; // camera side offers back to back when set
    int idle_cycles   = 0;
    int cam_x_fp      = 0;    // camera position in fixed point, walked per item
    int cam_z_fp      = 0;

    always #1 i_clk = ~i_clk;

    initial res_ch.ready = 1'b0;

    // Result side: check every accepted word, then pick next cycle's ready.
    // Mostly ready, some short stalls, a few long ones, stretches with none, and once a
    // long hold-off so the sweep freezes and the camera side backs up.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            tracker.check_word('{res_ch.slot, res_ch.tile_x, res_ch.tile_y,
                                 res_ch.level, res_ch.reinit, res_ch.last});
            words_seen++;
        end
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end else if (!pressure_done && words_seen >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            stall_left    = PRESSURE_LEN - 1;
            res_ch.ready <= 1'b0;
        end else if (calm_left > 0) begin
            res_ch.ready <= 1'b1;
            calm_left--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                calm_left = $urandom_range(60, 400);
                res_ch.ready <= 1'b1;
            end else if (roll < 25) begin
                stall_left = $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end else if (roll < 27) begin
                stall_left = $urandom_range(15, 60);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: any stretch with no handshake on either side beyond the limit
    // means the block hung or dropped words.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cam_ch.valid && cam_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles < IDLE_LIMIT) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic int clamp_cam(int v);
        return (v < CAM_MIN) ? CAM_MIN : ((v > CAM_MAX) ? CAM_MAX : v);
    endfunction

    // Move one axis of the camera according to the chosen kind of move
    function automatic int nudge(int v, int mode);
        logic signed [tlod_pkg::CAM_W-1:0] raw;
        case (mode)
            0: ;                                                        // stand still
            1: v = (v & ~255) | int'($urandom_range(0, 255));          // sub-tile jitter
            2: v = v + int'($urandom_range(0, 1024)) - 512;            // up to 2 tiles
            3: v = v + int'($urandom_range(0, 4096)) - 2048;           // up to 8 tiles
            4: begin
                raw = tlod_pkg::CAM_W'($urandom());
                v   = int'(raw);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = CAM_MIN;
                    1:       v = CAM_MAX;
                    2:       v = -HALF_LSB;
                    default: v = HALF_LSB;
                endcase
            end
        endcase
        return clamp_cam(v);
    endfunction

    // Mostly small walks so slots stay hit and levels step down;
    // some jumps, full-range noise and extremes.
    task automatic advance_camera();
        int r;
        int mode;
        r = $urandom_range(0, 99);
        if (r < 20)      mode = 0;
        else if (r < 35) mode = 1;
        else if (r < 70) mode = 2;
        else if (r < 85) mode = 3;
        else if (r < 95) mode = 4;
        else             mode = 5;
        cam_x_fp = nudge(cam_x_fp, mode);
        cam_z_fp = nudge(cam_z_fp, mode);
    endtask

    // Offer one camera word and hold it until accepted. valid stays high on
    // return so the next word can follow without a bubble; the caller drops
    // it in the same step when no word follows.
    task automatic send_camera(input int fx, input int fz);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            cam_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cam_ch.valid    <= 1'b1;
        cam_ch.camera_x <= tlod_pkg::CAM_W'(fx);
        cam_ch.camera_z <= tlod_pkg::CAM_W'(fz);
        @(posedge i_clk);
        while (!cam_ch.ready) @(posedge i_clk);
        tracker.take_camera(tlod_pkg::CAM_W'(fx), tlod_pkg::CAM_W'(fz));
    endtask

    // Write lod_levels only once the block is drained and idle
    task automatic write_lod(input logic [tlod_pkg::LOD_W-1:0] v);
        cam_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_lod(v);
    endtask

    initial begin : stimulus
        tracker = new();
        cam_ch.valid    <= 1'b0;
        cam_ch.camera_x <= '0;
        cam_ch.camera_z <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset lod_levels first.
        // Empty table: every slot rebuilt at the coarsest level, then the
        // repeats let the levels step down one per update.
        repeat (4) send_camera(0, 0);
        send_camera(HALF_LSB, -HALF_LSB);           // exact half rounds away from zero
        send_camera(HALF_LSB - 1, -(HALF_LSB - 1)); // just below half rounds to zero
        send_camera(383, -384);
        send_camera(-1, 1);
        send_camera(CAM_MAX, CAM_MIN);              // extreme corners of the range
        send_camera(CAM_MIN, CAM_MAX);
        repeat (2) send_camera(CAM_MAX, CAM_MAX);
        send_camera(CAM_MIN, CAM_MIN);
        // Levels above the new coarsest after a cfg drop must walk down by one
        write_lod(4'd8);
        repeat (2) send_camera(1280, -1280);
        write_lod(4'd2);
        repeat (3) send_camera(1280, -1280);

        // Random phases, one lod_levels setting each
        cam_x_fp = 1280;
        cam_z_fp = -1280;
        for (int p = 0; p < 10; p++) begin
            write_lod(PHASE_LODS[p]);
            sender_calm = (p % 3 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                advance_camera();
                send_camera(cam_x_fp, cam_z_fp);
            end
        end
        cam_ch.valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
src/tlod_pkg.sv
src/tlod_ifs.sv
src/tlod_eval.sv
src/toroidal_tile_lod_scheduler.sv
tb/toroidal_tile_lod_scheduler_tb.sv
